// File: rtl/firmware_update_receiver_macros.svh
// ---------------------------------------------------------------------------
// Firmware update receiver assertion macros
// Shared concurrent-check shorthands; every user has clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef FIRMWARE_UPDATE_RECEIVER_MACROS_SVH
`define FIRMWARE_UPDATE_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FUR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fur_pkg.sv
// ---------------------------------------------------------------------------
// fur_pkg
// Types, constants and helpers shared by the firmware update receiver.
// ---------------------------------------------------------------------------
package fur_pkg;

  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 16;
  localparam int KIND_W       = 3;
  localparam int PAGE_OUT_W   = 8;
  localparam int OFFSET_OUT_W = 10;
  localparam int MAX_RESULTS  = 3;
  localparam int RES_CNT_W    = 2;

  localparam int PAGE_BYTES_DEF       = 1024;
  localparam int PAGE_NUMBER_BITS_DEF = 8;

  localparam logic [BYTE_W-1:0] CHAR_U   = 8'h55;
  localparam logic [BYTE_W-1:0] CHAR_B   = 8'h42;
  localparam logic [BYTE_W-1:0] HOST_OK  = 8'h00;
  localparam logic [BYTE_W-1:0] HOST_ERR = 8'h01;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND   = 3'd0,
    KIND_STORE  = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_META   = 3'd3,
    KIND_RESET  = 3'd4,
    KIND_BOOT   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [BYTE_W-1:0]        host_byte;
    logic [PAGE_OUT_W-1:0]    page_number;
    logic [OFFSET_OUT_W-1:0]  byte_offset;
    logic [BYTE_W-1:0]        data_byte;
    logic [WORD_W-1:0]        meta_version;
    logic [WORD_W-1:0]        meta_size;
    logic                     last;
  } result_t;

  function automatic result_t make_result(
    kind_t                   kind,
    logic [BYTE_W-1:0]       host_byte,
    logic [PAGE_OUT_W-1:0]   page_number,
    logic [OFFSET_OUT_W-1:0] byte_offset,
    logic [BYTE_W-1:0]       data_byte,
    logic [WORD_W-1:0]       meta_version,
    logic [WORD_W-1:0]       meta_size
  );
    result_t r;
    r.kind         = kind;
    r.host_byte    = host_byte;
    r.page_number  = page_number;
    r.byte_offset  = byte_offset;
    r.data_byte    = data_byte;
    r.meta_version = meta_version;
    r.meta_size    = meta_size;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/firmware_update_receiver.sv
// ---------------------------------------------------------------------------
// firmware_update_receiver
// Host-byte protocol decoder for in-field firmware updates.
// ---------------------------------------------------------------------------
// Feed host link bytes on the in_ channel, one byte per beat. Each byte
// produces zero to three result beats on the out_ channel, in order, with
// out_last marking the final beat belonging to that byte. Results are held
// in a three-entry output queue; a byte that yields zero or one result is
// taken every cycle while out_ready is high, a byte that yields more results
// keeps in_ready low while more than one of its results is queued (one result
// beat per cycle with out_ready high). Idle: 'U' is
// echoed and starts an update, 'B' is echoed and followed by a boot request,
// anything else is dropped. An update takes a little-endian 16-bit version
// and size; a nonzero version older than stored_version sends error byte 1
// and a reset request, otherwise a metadata write (version 0 keeps the stored
// version, which is also loaded with the written one) and ok byte 0 follow.
// Frames then arrive with a big-endian 16-bit length; each data byte comes
// out as a store beat with page and offset, a full page of PAGE_BYTES emits a
// commit, and every frame end sends 0. A zero length ends the update,
// committing the current page unless it is the very first frame. Write
// cfg_stored_version only while the block is idle; cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "firmware_update_receiver_macros.svh"

module firmware_update_receiver #(
  parameter int PAGE_BYTES       = fur_pkg::PAGE_BYTES_DEF,
  parameter int PAGE_NUMBER_BITS = fur_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // host byte channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fur_pkg::BYTE_W-1:0]          in_rx_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fur_pkg::KIND_W-1:0]          out_kind,
  output logic [fur_pkg::BYTE_W-1:0]          out_host_byte,
  output logic [fur_pkg::PAGE_OUT_W-1:0]      out_page_number,
  output logic [fur_pkg::OFFSET_OUT_W-1:0]    out_byte_offset,
  output logic [fur_pkg::BYTE_W-1:0]          out_data_byte,
  output logic [fur_pkg::WORD_W-1:0]          out_meta_version,
  output logic [fur_pkg::WORD_W-1:0]          out_meta_size,
  output logic                                out_last,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fur_pkg::WORD_W-1:0]          cfg_stored_version
);
  import fur_pkg::*;

  result_t [MAX_RESULTS-1:0] res;
  logic [RES_CNT_W-1:0]      res_cnt;

  // output queue: slot 0 is the head shown on the out_ ports
  result_t [MAX_RESULTS-1:0] q_r, q_nxt;
  logic [RES_CNT_W-1:0]      cnt_r, cnt_nxt;

  logic in_fire;
  logic pop;

  assign cfg_ready = 1'b1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  // take a new byte once the queue is empty or its last entry leaves now
  assign in_ready  = (cnt_r == '0) | ((cnt_r == RES_CNT_W'(1)) & out_ready);
  assign in_fire   = in_valid & in_ready;

  fur_ctrl #(
    .PAGE_BYTES       (PAGE_BYTES),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .rx_byte  (in_rx_byte),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_stored_version),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (in_fire) begin
      q_nxt   = res;
      cnt_nxt = res_cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_kind         = q_r[0].kind;
  assign out_host_byte    = q_r[0].host_byte;
  assign out_page_number  = q_r[0].page_number;
  assign out_byte_offset  = q_r[0].byte_offset;
  assign out_data_byte    = q_r[0].data_byte;
  assign out_meta_version = q_r[0].meta_version;
  assign out_meta_size    = q_r[0].meta_size;
  assign out_last         = q_r[0].last;

  `FUR_ASSERT_NOW(a_tail_is_last, out_valid && cnt_r == RES_CNT_W'(1), out_last, "final queued beat lacks last")
  `FUR_ASSERT_NEXT(a_more_follow, pop && !out_last, out_valid, "beat group cut short")
  `FUR_ASSERT_NEXT(a_results_show, in_fire && res_cnt != '0, out_valid, "results of accepted byte lost")

endmodule

// File: rtl/fur_ctrl.sv
// ---------------------------------------------------------------------------
// fur_ctrl
// Protocol state machine: decodes one host byte per beat into up to three
// results and holds the version/size/frame/page bookkeeping.
// ---------------------------------------------------------------------------
`include "firmware_update_receiver_macros.svh"

module fur_ctrl #(
  parameter int PAGE_BYTES       = fur_pkg::PAGE_BYTES_DEF,
  parameter int PAGE_NUMBER_BITS = fur_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_fire,
  input  logic [fur_pkg::BYTE_W-1:0]                    rx_byte,
  input  logic                                          cfg_we,
  input  logic [fur_pkg::WORD_W-1:0]                    cfg_data,
  output fur_pkg::result_t [fur_pkg::MAX_RESULTS-1:0]   res,
  output logic [fur_pkg::RES_CNT_W-1:0]                 res_cnt
);
  import fur_pkg::*;

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAGE_BYTES - 1);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_VER_LO  = 4'd1,
    PH_VER_HI  = 4'd2,
    PH_SIZE_LO = 4'd3,
    PH_SIZE_HI = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_DATA    = 4'd7
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [WORD_W-1:0]           stored_version_r, stored_version_nxt;
  logic [WORD_W-1:0]           new_version_r, new_version_nxt;
  logic [WORD_W-1:0]           image_size_r, image_size_nxt;
  logic [WORD_W-1:0]           frame_rem_r, frame_rem_nxt;
  logic                        first_frame_r, first_frame_nxt;
  logic [OFF_W-1:0]            fill_offset_r, fill_offset_nxt;
  logic [PAGE_NUMBER_BITS-1:0] page_r, page_nxt;

  logic [WORD_W-1:0]           ver_full;
  logic [WORD_W-1:0]           size_full;
  logic [WORD_W-1:0]           ver_eff;
  logic [WORD_W-1:0]           len_full;
  logic [WORD_W-1:0]           frame_dec;
  logic [PAGE_OUT_W-1:0]       page_out;
  result_t [MAX_RESULTS-1:0]   res_raw;
  logic [RES_CNT_W-1:0]        cnt;

  assign ver_full  = {rx_byte, new_version_r[BYTE_W-1:0]};
  assign size_full = {rx_byte, image_size_r[BYTE_W-1:0]};
  assign ver_eff   = (new_version_r == '0) ? stored_version_r : new_version_r;
  assign len_full  = {frame_rem_r[WORD_W-1:BYTE_W], rx_byte};
  assign frame_dec = frame_rem_r - WORD_W'(1);
  assign page_out  = PAGE_OUT_W'(page_r);

  always_comb begin
    phase_nxt          = phase_r;
    stored_version_nxt = stored_version_r;
    new_version_nxt    = new_version_r;
    image_size_nxt     = image_size_r;
    frame_rem_nxt      = frame_rem_r;
    first_frame_nxt    = first_frame_r;
    fill_offset_nxt    = fill_offset_r;
    page_nxt           = page_r;
    res_raw            = '0;
    cnt                = '0;

    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CHAR_U) begin
          res_raw[0] = make_result(KIND_SEND, rx_byte, '0, '0, '0, '0, '0);
          cnt        = 2'd1;
          phase_nxt  = PH_VER_LO;
        end else if (rx_byte == CHAR_B) begin
          res_raw[0] = make_result(KIND_SEND, rx_byte, '0, '0, '0, '0, '0);
          res_raw[1] = make_result(KIND_BOOT, '0, '0, '0, '0, '0, '0);
          cnt        = 2'd2;
        end
      end
      PH_VER_LO: begin
        new_version_nxt = {{BYTE_W{1'b0}}, rx_byte};
        phase_nxt       = PH_VER_HI;
      end
      PH_VER_HI: begin
        new_version_nxt = ver_full;
        phase_nxt       = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        image_size_nxt = {{BYTE_W{1'b0}}, rx_byte};
        phase_nxt      = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        image_size_nxt = size_full;
        if (new_version_r != '0 && new_version_r < stored_version_r) begin
          // image older than what is in flash: refuse and ask for reset
          res_raw[0] = make_result(KIND_SEND, HOST_ERR, '0, '0, '0, '0, '0);
          res_raw[1] = make_result(KIND_RESET, '0, '0, '0, '0, '0, '0);
          cnt        = 2'd2;
          phase_nxt  = PH_IDLE;
        end else begin
          new_version_nxt    = ver_eff;
          stored_version_nxt = ver_eff;
          res_raw[0] = make_result(KIND_META, '0, '0, '0, '0, ver_eff, size_full);
          res_raw[1] = make_result(KIND_SEND, HOST_OK, '0, '0, '0, '0, '0);
          cnt             = 2'd2;
          first_frame_nxt = 1'b1;
          fill_offset_nxt = '0;
          page_nxt        = '0;
          frame_rem_nxt   = '0;
          phase_nxt       = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        frame_rem_nxt = {rx_byte, {BYTE_W{1'b0}}};
        phase_nxt     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_rem_nxt = len_full;
        if (len_full == '0) begin
          // end of image: flush the partial page unless nothing was sent
          if (!first_frame_r) begin
            res_raw[0] = make_result(KIND_COMMIT, '0, page_out, '0, '0, '0, '0);
            cnt        = 2'd1;
          end
          phase_nxt = PH_IDLE;
        end else begin
          first_frame_nxt = 1'b0;
          phase_nxt       = PH_DATA;
        end
      end
      PH_DATA: begin
        res_raw[0] = make_result(KIND_STORE, '0, page_out,
                                 OFFSET_OUT_W'(fill_offset_r), rx_byte, '0, '0);
        cnt = 2'd1;
        if (fill_offset_r == OFF_LAST) begin
          res_raw[cnt] = make_result(KIND_COMMIT, '0, page_out, '0, '0, '0, '0);
          cnt             = cnt + 2'd1;
          page_nxt        = page_r + PAGE_NUMBER_BITS'(1);
          fill_offset_nxt = '0;
        end else begin
          fill_offset_nxt = fill_offset_r + OFF_W'(1);
        end
        frame_rem_nxt = frame_dec;
        if (frame_dec == '0) begin
          res_raw[cnt] = make_result(KIND_SEND, HOST_OK, '0, '0, '0, '0, '0);
          cnt          = cnt + 2'd1;
          phase_nxt    = PH_LEN_HI;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res = res_raw;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = (RES_CNT_W'(i + 1) == cnt);
    end
  end

  assign res_cnt = cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      stored_version_r <= '0;
      new_version_r    <= '0;
      image_size_r     <= '0;
      frame_rem_r      <= '0;
      first_frame_r    <= 1'b1;
      fill_offset_r    <= '0;
      page_r           <= '0;
    end else if (in_fire) begin
      phase_r          <= phase_nxt;
      stored_version_r <= stored_version_nxt;
      new_version_r    <= new_version_nxt;
      image_size_r     <= image_size_nxt;
      frame_rem_r      <= frame_rem_nxt;
      first_frame_r    <= first_frame_nxt;
      fill_offset_r    <= fill_offset_nxt;
      page_r           <= page_nxt;
    end else if (cfg_we) begin
      stored_version_r <= cfg_data;
    end
  end

  `FUR_ASSERT_NOW(a_data_len_nonzero, phase_r == PH_DATA, frame_rem_r != '0, "data phase with empty frame")
  `FUR_ASSERT_NOW(a_offset_in_page, 1'b1, fill_offset_r <= OFF_LAST, "fill offset beyond page")

endmodule
